// ----- hw/rtl/xq_pkg.sv -----
// shared constants, result structs and helper functions for the xterm 256-colour quantizer
package xq_pkg;

  // pipeline depth of each error path, input register to path result
  localparam int PATH_LATENCY = 6;

  // squared error of three 8-bit channels fits in 18 bits
  localparam int ERR_W  = 18;
  localparam int STEP_W = 5;
  localparam int LVL_W  = 3;

  // palette layout
  localparam logic [7:0] CUBE_BASE     = 8'd16;
  localparam logic [7:0] GREY_BASE     = 8'd232;
  localparam logic [7:0] CUBE_R_WEIGHT = 8'd36;
  localparam logic [7:0] CUBE_G_WEIGHT = 8'd6;

  // grey ramp: level = GREY_OFFSET + GREY_SPACING * step
  localparam logic [7:0]        GREY_OFFSET   = 8'd8;
  localparam logic [7:0]        GREY_SPACING  = 8'd10;
  localparam logic [7:0]        GREY_ROUND    = 8'd5;
  localparam logic [STEP_W-1:0] GREY_MAX_STEP = 5'd23;

  // reciprocal constants: x/3 ~ (x*683)>>11 for x <= 765, x/10 ~ (x*205)>>11 for x <= 252
  localparam logic [19:0] AVG_RECIP  = 20'd683;
  localparam logic [15:0] STEP_RECIP = 16'd205;
  localparam int          RECIP_SHIFT = 11;

  // cube level codes
  localparam logic [LVL_W-1:0] LVL_0   = 3'd0;
  localparam logic [LVL_W-1:0] LVL_95  = 3'd1;
  localparam logic [LVL_W-1:0] LVL_135 = 3'd2;
  localparam logic [LVL_W-1:0] LVL_175 = 3'd3;
  localparam logic [LVL_W-1:0] LVL_215 = 3'd4;
  localparam logic [LVL_W-1:0] LVL_255 = 3'd5;

  typedef struct packed {
    logic [ERR_W-1:0] err;
    logic [7:0]       idx;
  } cube_res_t;

  typedef struct packed {
    logic [ERR_W-1:0]  err;
    logic [STEP_W-1:0] step;
  } grey_res_t;

  // nearest cube level, a tie at a midpoint going to the lower level
  function automatic logic [LVL_W-1:0] snap_level(input logic [7:0] v);
    logic [LVL_W-1:0] code;
    priority if (v < 8'd48) code = LVL_0;
    else if (v <= 8'd115) code = LVL_95;
    else if (v <= 8'd155) code = LVL_135;
    else if (v <= 8'd195) code = LVL_175;
    else if (v <= 8'd235) code = LVL_215;
    else code = LVL_255;
    return code;
  endfunction

  // channel value of a cube level code
  function automatic logic [7:0] cube_level(input logic [LVL_W-1:0] code);
    logic [7:0] lvl;
    unique case (code)
      LVL_0:   lvl = 8'd0;
      LVL_95:  lvl = 8'd95;
      LVL_135: lvl = 8'd135;
      LVL_175: lvl = 8'd175;
      LVL_215: lvl = 8'd215;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- hw/rtl/rgb_to_xterm256_quantizer.sv -----
// top level of the rgb to xterm 256-colour quantizer: stream ports, valid pipeline, slot choice
//
// Maps each 24-bit RGB pixel to the nearest xterm 256-colour slot: the colour cube slot
// 16..231 unless the single grey ramp candidate 232..255 has a strictly smaller squared
// error. One pixel is taken every clock except during an output stall; each result passes
// a six-stage error pipeline (two paths run side by side) and then the output register.
// The whole pipeline advances together and halts only while a result sits in the output
// register with m_axis_tready low; no pixel is lost or repeated across a stall.
// There is no state between pixels and nothing to configure.
module rgb_to_xterm256_quantizer import xq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // palette_index [7:0]
);

  logic en;
  logic [PATH_LATENCY-1:0] vld;
  cube_res_t cube_res;
  grey_res_t grey_res;

  // pipeline moves whenever the output register is free or being emptied
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  xq_cube_path u_cube (
    .clk   (clk),
    .en    (en),
    .red   (s_axis_tdata[7:0]),
    .green (s_axis_tdata[15:8]),
    .blue  (s_axis_tdata[23:16]),
    .res   (cube_res)
  );

  xq_grey_path u_grey (
    .clk   (clk),
    .en    (en),
    .red   (s_axis_tdata[7:0]),
    .green (s_axis_tdata[15:8]),
    .blue  (s_axis_tdata[23:16]),
    .res   (grey_res)
  );

  // valid bits travelling alongside the path stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PATH_LATENCY-2:0], s_axis_tvalid};
    end
  end

  // output register: grey wins only on a strictly smaller error
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld[PATH_LATENCY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (grey_res.err < cube_res.err) begin
        m_axis_tdata <= GREY_BASE + 8'(grey_res.step);
      end else begin
        m_axis_tdata <= cube_res.idx;
      end
    end
  end

`ifndef SYNTHESIS
  // every result lies in the cube or grey part of the palette
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata >= CUBE_BASE)
    else $error("palette index below the cube base");

  // an accepted pixel enters the first pipeline stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted pixel missing from stage one");

  // a stalled output freezes the whole valid pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld))
    else $error("pipeline moved during an output stall");
`endif

endmodule

// ----- hw/rtl/xq_cube_path.sv -----
// colour cube path: channel snapping, cube slot and squared error
module xq_cube_path import xq_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output cube_res_t  res
);

  // stage 1: pixel and snapped level codes
  logic [7:0]       r1, g1, b1;
  logic [LVL_W-1:0] rl1, gl1, bl1;
  always_ff @(posedge clk) begin
    if (en) begin
      r1  <= red;
      g1  <= green;
      b1  <= blue;
      rl1 <= snap_level(red);
      gl1 <= snap_level(green);
      bl1 <= snap_level(blue);
    end
  end

  // stage 2: channel distances and cube slot
  logic [7:0] dr2, dg2, db2, idx2;
  always_ff @(posedge clk) begin
    if (en) begin
      dr2  <= abs_diff(r1, cube_level(rl1));
      dg2  <= abs_diff(g1, cube_level(gl1));
      db2  <= abs_diff(b1, cube_level(bl1));
      idx2 <= CUBE_BASE + 8'(rl1) * CUBE_R_WEIGHT + 8'(gl1) * CUBE_G_WEIGHT + 8'(bl1);
    end
  end

  // stage 3: squares
  logic [15:0] sr3, sg3, sb3;
  logic [7:0]  idx3;
  always_ff @(posedge clk) begin
    if (en) begin
      sr3  <= 16'(dr2) * 16'(dr2);
      sg3  <= 16'(dg2) * 16'(dg2);
      sb3  <= 16'(db2) * 16'(db2);
      idx3 <= idx2;
    end
  end

  // stage 4: error sum, then two delay stages to line up with the grey path
  cube_res_t s4, s5, s6;
  always_ff @(posedge clk) begin
    if (en) begin
      s4.err <= ERR_W'(sr3) + ERR_W'(sg3) + ERR_W'(sb3);
      s4.idx <= idx3;
      s5     <= s4;
      s6     <= s5;
    end
  end

  assign res = s6;

endmodule

// ----- hw/rtl/xq_grey_path.sv -----
// grey ramp path: channel average, ramp step and squared error
module xq_grey_path import xq_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output grey_res_t  res
);

  // stage 1: pixel and channel sum
  logic [7:0] r1, g1, b1;
  logic [9:0] sum1;
  always_ff @(posedge clk) begin
    if (en) begin
      r1   <= red;
      g1   <= green;
      b1   <= blue;
      sum1 <= 10'(red) + 10'(green) + 10'(blue);
    end
  end

  // stage 2: average by reciprocal multiply
  logic [7:0]  r2, g2, b2, avg2;
  logic [19:0] avg_prod;
  assign avg_prod = 20'(sum1) * AVG_RECIP;
  always_ff @(posedge clk) begin
    if (en) begin
      r2   <= r1;
      g2   <= g1;
      b2   <= b1;
      avg2 <= avg_prod[RECIP_SHIFT +: 8];
    end
  end

  // stage 3: rounded ramp step, zero below the first level and clamped to the top of the ramp
  logic [7:0]        r3, g3, b3;
  logic [STEP_W-1:0] step3;
  logic [15:0]       step_prod;
  logic [STEP_W-1:0] step_raw;
  assign step_prod = 16'(avg2 - (GREY_OFFSET - GREY_ROUND)) * STEP_RECIP;
  assign step_raw  = step_prod[RECIP_SHIFT +: STEP_W];
  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= r2;
      g3 <= g2;
      b3 <= b2;
      priority if (avg2 < GREY_OFFSET) step3 <= '0;
      else if (step_raw > GREY_MAX_STEP) step3 <= GREY_MAX_STEP;
      else step3 <= step_raw;
    end
  end

  // stage 4: distances to the grey level
  logic [7:0]        grey;
  logic [7:0]        dr4, dg4, db4;
  logic [STEP_W-1:0] step4;
  assign grey = GREY_OFFSET + 8'(step3) * GREY_SPACING;
  always_ff @(posedge clk) begin
    if (en) begin
      dr4   <= abs_diff(r3, grey);
      dg4   <= abs_diff(g3, grey);
      db4   <= abs_diff(b3, grey);
      step4 <= step3;
    end
  end

  // stage 5: squares
  logic [15:0]       sr5, sg5, sb5;
  logic [STEP_W-1:0] step5;
  always_ff @(posedge clk) begin
    if (en) begin
      sr5   <= 16'(dr4) * 16'(dr4);
      sg5   <= 16'(dg4) * 16'(dg4);
      sb5   <= 16'(db4) * 16'(db4);
      step5 <= step4;
    end
  end

  // stage 6: error sum
  grey_res_t s6;
  always_ff @(posedge clk) begin
    if (en) begin
      s6.err  <= ERR_W'(sr5) + ERR_W'(sg5) + ERR_W'(sb5);
      s6.step <= step5;
    end
  end

  assign res = s6;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the rgb to xterm 256-colour quantizer
module testbench;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_GAP         = 15;
  localparam int MAX_BURST       = 20;

  // palette layout and cube levels for the predictor
  localparam int CUBE_BASE_SLOT  = 16;
  localparam int GREY_BASE_SLOT  = 232;
  localparam int GREY_TOP_STEP   = 23;
  localparam int CUBE_STEPS [6]  = '{0, 95, 135, 175, 215, 255};
  // channel values at or next to the snapping boundaries
  localparam int CUBE_EDGES [5]  = '{47, 115, 155, 195, 235};

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum logic {TX_BACK_TO_BACK, TX_BURSTY} tx_mode_t;

  typedef struct {
    logic [23:0] pixel;
    logic [7:0]  slot;
  } slot_expect_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // red [7:0], green [15:8], blue [23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // palette_index [7:0]

  slot_expect_t pending_slots [$];

  rx_mode_t rx_mode = RX_ALWAYS;
  tx_mode_t tx_mode = TX_BACK_TO_BACK;
  int       hold_off_req = 0;
  int       hold_off_ack = 0;
  int       hold_left = 0;
  int       pattern_phase = 0;
  int       burst_left = 0;

  int mismatches = 0;
  int pixels_sent = 0;
  int ties_sent = 0;
  int cube_slots = 0;
  int grey_slots = 0;
  int input_stalls = 0;
  int quiet_cycles = 0;

  rgb_to_xterm256_quantizer DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // nearest palette slot; also flags pixels where cube and grey errors are equal
  function automatic logic [7:0] nearest_xterm_slot(input logic [7:0] red, green, blue,
                                                    output bit err_tie);
    int chan [3];
    int lvl [3];
    int best_dist;
    int lvl_gap;
    int cube_err;
    int grey_err;
    int avg;
    int step;
    int grey;
    chan[0] = red;
    chan[1] = green;
    chan[2] = blue;
    cube_err = 0;
    grey_err = 0;
    for (int k = 0; k < 3; k++) begin
      lvl[k] = 0;
      best_dist = chan[k];
      // strict compare keeps the lower level on a tie
      for (int i = 1; i < 6; i++) begin
        lvl_gap = (chan[k] > CUBE_STEPS[i]) ? chan[k] - CUBE_STEPS[i] : CUBE_STEPS[i] - chan[k];
        if (lvl_gap < best_dist) begin
          best_dist = lvl_gap;
          lvl[k] = i;
        end
      end
      cube_err += best_dist * best_dist;
    end
    avg = (chan[0] + chan[1] + chan[2]) / 3;
    step = (avg < 8) ? 0 : (avg - 3) / 10;
    if (step > GREY_TOP_STEP) step = GREY_TOP_STEP;
    grey = 8 + 10 * step;
    for (int k = 0; k < 3; k++) grey_err += (chan[k] - grey) * (chan[k] - grey);
    err_tie = (grey_err == cube_err);
    if (grey_err < cube_err) return 8'(GREY_BASE_SLOT + step);
    return 8'(CUBE_BASE_SLOT + 36 * lvl[0] + 6 * lvl[1] + lvl[2]);
  endfunction

  // channel value near base, clamped to 0..255
  function automatic logic [7:0] jitter(input int base, input int spread);
    int v;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [7:0] edge_channel();
    return jitter(CUBE_EDGES[$urandom_range(0, 4)], 2);
  endfunction

  // one pixel transfer, followed by a random gap at the end of each burst when bursty
  task automatic send_pixel(input logic [7:0] red, green, blue);
    bit           err_tie;
    slot_expect_t item;
    int           gap;
    item.pixel = {blue, green, red};
    item.slot  = nearest_xterm_slot(red, green, blue, err_tie);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item.pixel;
    do @(posedge clk); while (!s_axis_tready);
    pending_slots.insert(pending_slots.size(), item);
    pixels_sent++;
    if (err_tie) ties_sent++;
    if (tx_mode == TX_BURSTY) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, MAX_BURST);
        gap = $urandom_range(1, MAX_GAP);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic shuffle_modes();
    rx_mode = rx_mode_t'($urandom_range(0, 2));
    tx_mode = tx_mode_t'($urandom_range(0, 1));
  endtask

  // corners, boundary ties, grey ramp ends and equal-error pixels
  task automatic test_directed();
    int  found;
    bit  err_tie;
    logic [7:0] b;
    rx_mode = RX_ALWAYS;
    tx_mode = TX_BACK_TO_BACK;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd240);
    // midpoints between cube levels snap down; then values on either side of a boundary
    send_pixel(8'd115, 8'd155, 8'd195);
    send_pixel(8'd235, 8'd115, 8'd155);
    send_pixel(8'd47, 8'd48, 8'd116);
    // grey ramp bottom, below the first step, and the clamped top
    send_pixel(8'd7, 8'd7, 8'd7);
    send_pixel(8'd8, 8'd8, 8'd8);
    send_pixel(8'd18, 8'd19, 8'd17);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd238, 8'd238, 8'd238);
    send_pixel(8'd250, 8'd252, 8'd254);
    send_pixel(8'd13, 8'd12, 8'd13);
    // pixels where grey and cube errors are equal: cube slot expected
    found = 0;
    for (int r = 0; r < 256 && found < 6; r++) begin
      for (int g = 0; g < 256 && found < 6; g += 3) begin
        b = 8'((r + g + 1) / 2);
        void'(nearest_xterm_slot(8'(r), 8'(g), b, err_tie));
        if (err_tie) begin
          send_pixel(8'(r), 8'(g), b);
          found++;
        end
      end
    end
  endtask

  // mix of uniform, near-grey and boundary pixels under changing flow patterns
  task automatic test_random_pixels(input int count);
    int kind;
    int base;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 0) shuffle_modes();
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind < 7) begin
        base = $urandom_range(0, 255);
        send_pixel(jitter(base, 8), jitter(base, 8), jitter(base, 8));
      end else begin
        send_pixel(edge_channel(), edge_channel(), edge_channel());
      end
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_hold_off(input int count);
    int base;
    rx_mode = RX_ALWAYS;
    tx_mode = TX_BACK_TO_BACK;
    hold_off_req++;
    for (int n = 0; n < count; n++) begin
      base = $urandom_range(0, 255);
      send_pixel(8'(base), jitter(base, 30), 8'($urandom));
    end
  endtask

  // grey-ish pixels along the whole ramp, where grey and cube compete closely
  task automatic test_grey_ramp(input int count);
    int base;
    rx_mode = RX_RANDOM;
    tx_mode = TX_BURSTY;
    for (int n = 0; n < count; n++) begin
      base = (n * 37) % 256;
      send_pixel(jitter(base, 4), jitter(base, 4), jitter(base, 4));
    end
  endtask

  // receiver: hold-off on request, else the current stall pattern
  always @(negedge clk) begin
    if (hold_off_req != hold_off_ack) begin
      hold_off_ack = hold_off_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    pattern_phase = (pattern_phase + 1) % 11;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) >= 35);
        RX_PATTERN: m_axis_tready <= (pattern_phase >= 4);
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  // result check against the oldest outstanding slot
  always @(posedge clk) begin : check_results
    slot_expect_t head;
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_slots.size() == 0) begin
        $display("%0t: unexpected result slot %0d with nothing outstanding",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        head = pending_slots.pop_front();
        if (m_axis_tdata !== head.slot) begin
          $display("%0t: pixel r=%0d g=%0d b=%0d palette_index expected %0d, got %0d",
                   $time, head.pixel[7:0], head.pixel[15:8], head.pixel[23:16],
                   head.slot, m_axis_tdata);
          mismatches++;
        end else if (head.slot >= 8'(GREY_BASE_SLOT)) begin
          grey_slots++;
        end else begin
          cube_slots++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_slots.size());
      $display("** rgb_to_xterm256_quantizer: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_pixels(600);
    test_output_hold_off(200);
    test_grey_ramp(300);
    test_random_pixels(600);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    rx_mode = RX_RANDOM;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pixels converted: %0d to cube slots, %0d to grey slots, %0d equal-error",
             pixels_sent, cube_slots, grey_slots, ties_sent);
    $display("bursty and stalled flow, one %0d-cycle output hold-off, %0d input stall cycles",
             HOLD_OFF_CYCLES, input_stalls);
    if (mismatches == 0 && pending_slots.size() == 0) begin
      $display("** rgb_to_xterm256_quantizer: PASSED **");
    end else begin
      $display("** rgb_to_xterm256_quantizer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/xq_pkg.sv
hw/rtl/xq_cube_path.sv
hw/rtl/xq_grey_path.sv
hw/rtl/rgb_to_xterm256_quantizer.sv
dv/testbench.sv
